@@ src/adb_pkg.sv @@
// ----------------------------------------------------------------------------
// adb_pkg
// Shared types, constants and the underrun fade function of the audio DMA
// double buffer.
// ----------------------------------------------------------------------------
package adb_pkg;

    localparam int RING_FRAMES_DEF = 2048;
    localparam int LEN_W           = 18;
    localparam int CFG_W           = 12;
    localparam int FRAME_W         = 32;
    localparam int SAMPLE_W        = 16;

    typedef enum logic [1:0] {
        ACT_QUEUE = 2'd0,
        ACT_WORD  = 2'd1,
        ACT_PLAY  = 2'd2
    } t_action;

    typedef struct packed {
        logic [1:0]       action;
        logic [LEN_W-1:0] dma_length;
        logic [31:0]      sample_word;
        logic             dma_enabled;
    } t_in;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] frame_left;
        logic signed [SAMPLE_W-1:0] frame_right;
        logic                       word_accepted;
        logic                       status_busy;
        logic                       status_full;
        logic                       interrupt_pulse;
        logic [LEN_W-1:0]           remaining_length;
    } t_out;

    // Per-item status handed from slot control to the playback stage
    typedef struct packed {
        logic             play;
        logic             hit;
        logic             word_accepted;
        logic             busy;
        logic             full;
        logic             irq;
        logic [LEN_W-1:0] remaining;
    } t_stage;

    // Scale by 15/16, truncate toward zero
    function automatic logic [SAMPLE_W-1:0] fade16(input logic [SAMPLE_W-1:0] v);
        logic [SAMPLE_W-1:0] mag;
        logic [SAMPLE_W+3:0] prod;
        logic [SAMPLE_W-1:0] res;
        begin
            mag  = v[SAMPLE_W-1] ? (~v + SAMPLE_W'(1)) : v;
            prod = {mag, 4'b0000} - {4'b0000, mag};
            res  = prod[SAMPLE_W+3:4];
            fade16 = v[SAMPLE_W-1] ? (~res + SAMPLE_W'(1)) : res;
        end
    endfunction

endpackage

@@ src/adb_ram.sv @@
// ----------------------------------------------------------------------------
// adb_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module adb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/adb_ctrl.sv @@
// ----------------------------------------------------------------------------
// adb_ctrl
// DMA length slots, ring pointers and fill count; issues ring writes and
// reads for stored sample words and played frames.
// ----------------------------------------------------------------------------
module adb_ctrl #(
    parameter int RING_FRAMES = adb_pkg::RING_FRAMES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_acc,
    input  adb_pkg::t_in                   i_item,
    input  logic                           i_cfg_we,
    input  logic [adb_pkg::CFG_W-1:0]      i_cfg_data,
    output logic                           o_ram_we,
    output logic [$clog2(RING_FRAMES)-1:0] o_ram_waddr,
    output logic [adb_pkg::FRAME_W-1:0]    o_ram_wdata,
    output logic                           o_ram_re,
    output logic [$clog2(RING_FRAMES)-1:0] o_ram_raddr,
    output adb_pkg::t_stage                o_stage
);
    import adb_pkg::*;

    localparam int IDX_W = $clog2(RING_FRAMES);
    localparam int LIM_W = $clog2(RING_FRAMES + 1);
    localparam int CMP_W = (LIM_W > CFG_W) ? LIM_W : CFG_W;

    logic [IDX_W-1:0] r_rd_idx, n_rd_idx;
    logic [IDX_W-1:0] r_wr_idx, n_wr_idx;
    logic [LIM_W-1:0] r_fill, n_fill;
    logic [LIM_W-1:0] r_limit, n_limit;
    logic [LEN_W-1:0] r_primary, n_primary;
    logic [LEN_W-1:0] r_secondary, n_secondary;
    logic             r_busy, n_busy;
    logic             r_full, n_full;

    logic [LIM_W-1:0] wr_inc;
    logic [LIM_W-1:0] rd_inc;
    logic [LEN_W-1:0] prim_dec;
    logic [CMP_W-1:0] cfg_wide;
    logic             can_store;
    logic             can_read;
    logic             accepted;
    logic             irq;

    always_comb begin
        n_rd_idx    = r_rd_idx;
        n_wr_idx    = r_wr_idx;
        n_fill      = r_fill;
        n_limit     = r_limit;
        n_primary   = r_primary;
        n_secondary = r_secondary;
        n_busy      = r_busy;
        n_full      = r_full;
        accepted    = 1'b0;
        irq         = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_re    = 1'b0;

        wr_inc    = LIM_W'(r_wr_idx) + LIM_W'(1);
        rd_inc    = LIM_W'(r_rd_idx) + LIM_W'(1);
        prim_dec  = (r_primary > LEN_W'(4)) ? (r_primary - LEN_W'(4)) : '0;
        can_store = (r_fill < r_limit) && (r_primary != '0);
        can_read  = i_item.dma_enabled && (r_fill != '0);

        if (i_acc) begin
            case (i_item.action)
                ACT_QUEUE: begin
                    n_secondary = i_item.dma_length;
                    if (r_primary == '0) begin
                        n_primary   = i_item.dma_length;
                        n_secondary = '0;
                    end
                    n_busy = 1'b1;
                    n_full = (n_primary != '0) && (n_secondary != '0);
                end
                ACT_WORD: begin
                    if (can_store) begin
                        o_ram_we = 1'b1;
                        n_wr_idx = (wr_inc == r_limit) ? '0 : IDX_W'(wr_inc);
                        n_fill   = r_fill + LIM_W'(1);
                        accepted = 1'b1;
                        n_primary = prim_dec;
                        if (prim_dec == '0) begin
                            n_primary   = r_secondary;
                            n_secondary = '0;
                            n_full      = 1'b0;
                            n_busy      = (r_secondary != '0);
                            irq         = 1'b1;
                        end
                    end
                end
                ACT_PLAY: begin
                    if (can_read) begin
                        o_ram_re = 1'b1;
                        n_rd_idx = (rd_inc == r_limit) ? '0 : IDX_W'(rd_inc);
                        n_fill   = r_fill - LIM_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end

        cfg_wide = CMP_W'(i_cfg_data);
        if (i_cfg_we) begin
            if (cfg_wide == '0) begin
                n_limit = LIM_W'(1);
            end else if (cfg_wide > CMP_W'(RING_FRAMES)) begin
                n_limit = LIM_W'(RING_FRAMES);
            end else begin
                n_limit = LIM_W'(cfg_wide);
            end
            n_rd_idx = '0;
            n_wr_idx = '0;
            n_fill   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx    <= '0;
            r_wr_idx    <= '0;
            r_fill      <= '0;
            r_limit     <= LIM_W'(RING_FRAMES);
            r_primary   <= '0;
            r_secondary <= '0;
            r_busy      <= 1'b0;
            r_full      <= 1'b0;
        end else begin
            r_rd_idx    <= n_rd_idx;
            r_wr_idx    <= n_wr_idx;
            r_fill      <= n_fill;
            r_limit     <= n_limit;
            r_primary   <= n_primary;
            r_secondary <= n_secondary;
            r_busy      <= n_busy;
            r_full      <= n_full;
        end
    end

    assign o_ram_waddr = r_wr_idx;
    assign o_ram_wdata = {i_item.sample_word[15:0], i_item.sample_word[31:16]};
    assign o_ram_raddr = r_rd_idx;

    assign o_stage.play          = (i_item.action == ACT_PLAY) && i_item.dma_enabled;
    assign o_stage.hit           = (r_fill != '0);
    assign o_stage.word_accepted = accepted;
    assign o_stage.busy          = n_busy;
    assign o_stage.full          = n_full;
    assign o_stage.irq           = irq;
    assign o_stage.remaining     = {n_primary[LEN_W-1:3], 3'b000};

    a_fill_le_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_limit)
        else $error("fill count above ring limit");

    a_wr_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LIM_W'(r_wr_idx) < r_limit)
        else $error("write index outside ring");

    a_rd_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LIM_W'(r_rd_idx) < r_limit)
        else $error("read index outside ring");

    a_full_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |-> r_busy)
        else $error("full without busy");

endmodule

@@ src/adb_play.sv @@
// ----------------------------------------------------------------------------
// adb_play
// Ring read stage and output register: forms the played frame, applies the
// underrun fade and holds the last frame.
// ----------------------------------------------------------------------------
module adb_play (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_acc,
    input  adb_pkg::t_stage             i_stage,
    input  logic [adb_pkg::FRAME_W-1:0] i_rdata,
    output logic                        o_in_ready,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output adb_pkg::t_out               o_out_data
);
    import adb_pkg::*;

    logic                r_s1_valid;
    t_stage              r_s1;
    logic                r_out_valid;
    t_out                r_out;
    logic [SAMPLE_W-1:0] r_last_l;
    logic [SAMPLE_W-1:0] r_last_r;

    logic                move;
    logic [SAMPLE_W-1:0] n_left;
    logic [SAMPLE_W-1:0] n_right;
    t_out                n_out;

    assign move       = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || move;

    always_comb begin
        n_left  = '0;
        n_right = '0;
        if (r_s1.play) begin
            if (r_s1.hit) begin
                n_left  = i_rdata[SAMPLE_W-1:0];
                n_right = i_rdata[FRAME_W-1:SAMPLE_W];
            end else begin
                n_left  = fade16(r_last_l);
                n_right = fade16(r_last_r);
            end
        end
        n_out.frame_left       = n_left;
        n_out.frame_right      = n_right;
        n_out.word_accepted    = r_s1.word_accepted;
        n_out.status_busy      = r_s1.busy;
        n_out.status_full      = r_s1.full;
        n_out.interrupt_pulse  = r_s1.irq;
        n_out.remaining_length = r_s1.remaining;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_last_l    <= '0;
            r_last_r    <= '0;
        end else begin
            if (i_acc) begin
                r_s1_valid <= 1'b1;
            end else if (move) begin
                r_s1_valid <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
                if (r_s1.play) begin
                    r_last_l <= n_left;
                    r_last_r <= n_right;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_s1 <= i_stage;
        end
        if (move) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ src/audio_dma_double_buffer_fifo.sv @@
// ----------------------------------------------------------------------------
// audio_dma_double_buffer_fifo
// Audio DMA double buffer with primary and secondary length slots feeding a
// stereo frame ring held in one synchronous RAM.
//
// Input channel (i_in_valid / o_in_ready, i_in_data): one transfer per item,
// queue a DMA length, supply a DMA sample word, or play one frame.
// Output channel (o_out_valid / i_out_ready, o_out_data): exactly one result
// transfer per input item, in order.
// Config channel (i_cfg_valid / o_cfg_ready, i_cfg_data): ring frame limit,
// always ready; a write empties the ring. Write only while the block is idle.
// An input transfer passes the registered RAM read and read stage, then the
// output register, before its output transfer.
// Throughput is one item per cycle while the receiver keeps up, set by the
// single ring RAM write or read that an item needs at most.
// A stalled receiver holds the output register; the read stage behind it
// still takes one more item, then o_in_ready drops until the output drains.
// Synchronous reset clears slots, flags, pointers and the last played frame
// and sets the limit to the full ring; ring contents need no clearing.
// ----------------------------------------------------------------------------
module audio_dma_double_buffer_fifo #(
    parameter int RING_FRAMES = adb_pkg::RING_FRAMES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  adb_pkg::t_in              i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output adb_pkg::t_out             o_out_data,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [adb_pkg::CFG_W-1:0] i_cfg_data
);
    import adb_pkg::*;

    localparam int IDX_W = $clog2(RING_FRAMES);

    logic               acc;
    logic               cfg_we;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [FRAME_W-1:0] ram_wdata;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [FRAME_W-1:0] ram_rdata;
    t_stage             stage;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;
    assign acc         = i_in_valid && o_in_ready;

    adb_ctrl #(
        .RING_FRAMES(RING_FRAMES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc      (acc),
        .i_item     (i_in_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_ram_we   (ram_we),
        .o_ram_waddr(ram_waddr),
        .o_ram_wdata(ram_wdata),
        .o_ram_re   (ram_re),
        .o_ram_raddr(ram_raddr),
        .o_stage    (stage)
    );

    adb_ram #(
        .WIDTH(FRAME_W),
        .DEPTH(RING_FRAMES)
    ) u_ring (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    adb_play u_play (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc      (acc),
        .i_stage    (stage),
        .i_rdata    (ram_rdata),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

endmodule

@@ sim/adb_checker.sv @@
// ----------------------------------------------------------------------------
// adb_checker
// Watches the input, output and config channels of the audio DMA double
// buffer. It keeps its own image of the length slots, flags and frame ring,
// works out one expected result per input transfer, and compares every output
// transfer field by field against the oldest expected result.
// ----------------------------------------------------------------------------
module adb_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  adb_pkg::t_in              i_in_data,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  adb_pkg::t_out             i_out_data,
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_ready,
    input  logic [adb_pkg::CFG_W-1:0] i_cfg_data,
    output int                        o_fail_count,
    output int                        o_pending
);

    import adb_pkg::*;

    logic [FRAME_W-1:0]  ring_img [RING_FRAMES_DEF];
    int unsigned         rd_ptr;
    int unsigned         wr_ptr;
    int unsigned         fill;
    int unsigned         limit;
    logic [LEN_W-1:0]    prim_len;
    logic [LEN_W-1:0]    sec_len;
    logic [SAMPLE_W-1:0] last_l;
    logic [SAMPLE_W-1:0] last_r;
    logic                busy;
    logic                full;
    t_out                results_due [$];
    int                  fails;

    initial begin
        fails        = 0;
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic logic [SAMPLE_W-1:0] faded(input logic [SAMPLE_W-1:0] v);
        int x;
        int m;
        x = int'($signed(v));
        m = (x < 0) ? -x : x;
        m = (m * 15) / 16;
        if (x < 0) m = -m;
        return m[SAMPLE_W-1:0];
    endfunction

    task automatic clear_audio();
        rd_ptr   = 0;
        wr_ptr   = 0;
        fill     = 0;
        limit    = RING_FRAMES_DEF;
        prim_len = '0;
        sec_len  = '0;
        last_l   = '0;
        last_r   = '0;
        busy     = 1'b0;
        full     = 1'b0;
    endtask

    task automatic audio_step(input t_in it, output t_out res);
        logic [FRAME_W-1:0] w;
        res = '0;
        case (it.action)
            ACT_QUEUE: begin
                sec_len = it.dma_length;
                if (prim_len == '0) begin
                    prim_len = sec_len;
                    sec_len  = '0;
                end
                busy = 1'b1;
                full = (prim_len != '0) && (sec_len != '0);
            end
            ACT_WORD: begin
                if (fill < limit && prim_len != '0) begin
                    ring_img[wr_ptr] = {it.sample_word[15:0], it.sample_word[31:16]};
                    wr_ptr = (wr_ptr + 1) % limit;
                    fill++;
                    res.word_accepted = 1'b1;
                    prim_len = (prim_len > LEN_W'(4)) ? prim_len - LEN_W'(4) : '0;
                    if (prim_len == '0) begin
                        prim_len = sec_len;
                        sec_len  = '0;
                        busy     = 1'b1;
                        full     = 1'b0;
                        res.interrupt_pulse = 1'b1;
                        if (prim_len == '0) busy = 1'b0;
                    end
                end
            end
            ACT_PLAY: begin
                if (it.dma_enabled) begin
                    if (fill > 0) begin
                        w      = ring_img[rd_ptr];
                        rd_ptr = (rd_ptr + 1) % limit;
                        fill--;
                        last_l = w[15:0];
                        last_r = w[31:16];
                    end else begin
                        last_l = faded(last_l);
                        last_r = faded(last_r);
                    end
                    res.frame_left  = last_l;
                    res.frame_right = last_r;
                end
            end
            default: ;
        endcase
        res.status_busy      = busy;
        res.status_full      = full;
        res.remaining_length = prim_len & ~LEN_W'(7);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out due;
        t_out res;
        int unsigned v;
        if (!i_rst_n) begin
            clear_audio();
            results_due.delete();
        end else begin
            // drain first: a result never belongs to an item taken on the same edge
            if (i_out_valid && i_out_ready) begin
                if (results_due.size() == 0) begin
                    $error("output transfer with no result due");
                    fails++;
                end else begin
                    due = results_due.pop_front();
                    check_field("frame_left", 32'(due.frame_left), 32'(i_out_data.frame_left));
                    check_field("frame_right", 32'(due.frame_right),
                                32'(i_out_data.frame_right));
                    check_field("word_accepted", 32'(due.word_accepted),
                                32'(i_out_data.word_accepted));
                    check_field("status_busy", 32'(due.status_busy),
                                32'(i_out_data.status_busy));
                    check_field("status_full", 32'(due.status_full),
                                32'(i_out_data.status_full));
                    check_field("interrupt_pulse", 32'(due.interrupt_pulse),
                                32'(i_out_data.interrupt_pulse));
                    check_field("remaining_length", 32'(due.remaining_length),
                                32'(i_out_data.remaining_length));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                v = 32'(i_cfg_data);
                if (v == 0) v = 1;
                if (v > RING_FRAMES_DEF) v = RING_FRAMES_DEF;
                limit  = v;
                rd_ptr = 0;
                wr_ptr = 0;
                fill   = 0;
            end
            if (i_in_valid && i_in_ready) begin
                audio_step(i_in_data, res);
                results_due.push_back(res);
            end
        end
        o_pending    <= results_due.size();
        o_fail_count <= fails;
    end

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the audio DMA double buffer. A directed run covers
// slot promotion, refused words, saturation, silence, underrun fade and the
// unused action; then random phases, each under a new ring limit, with random
// idle bursts on both channels in all but the last phase, one long receiver
// stall and one drain pause. The checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;

    import adb_pkg::*;

    localparam logic [1:0] ACT_UNUSED  = 2'd3;
    localparam int         PHASES      = 12;
    localparam int         PHASE_ITEMS = 144;
    localparam int         HOLD_CYCLES = 300;
    localparam int         WATCH_LIMIT = 3000;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    t_in              in_data;
    logic             out_valid;
    logic             out_ready;
    t_out             out_data;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data;
    int               fail_count;
    int               pending;
    int               stall_cycles;
    bit               tx_idle;
    bit               rx_idle;
    bit               hold_req;

    always #2 clk = ~clk;

    audio_dma_double_buffer_fifo dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    adb_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge clk) begin
        if (!rst_n) begin
            stall_cycles <= 0;
        end else if ((in_valid && in_ready) || (out_valid && out_ready) ||
                     (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCH_LIMIT) begin
                $display("audio_dma_double_buffer_fifo verification failed");
                $finish;
            end
        end
    end

    // receiver side: random stalls, plus one long hold on request
    initial begin
        forever begin
            @(negedge clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end else if (rx_idle && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 6) - 1) @(negedge clk);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    function automatic t_in make_item(input logic [1:0] act, input logic [LEN_W-1:0] len,
                                      input logic [31:0] word, input logic en);
        t_in it;
        it.action      = act;
        it.dma_length  = len;
        it.sample_word = word;
        it.dma_enabled = en;
        return it;
    endfunction

    function automatic t_in random_item();
        t_in it;
        int  pick;
        int  r;
        it.dma_length  = LEN_W'($urandom);
        it.sample_word = $urandom;
        it.dma_enabled = ($urandom_range(0, 9) != 0);
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            it.action = ACT_QUEUE;
            r = $urandom_range(0, 9);
            if (r == 0)      it.dma_length = '0;
            else if (r == 1) it.dma_length = LEN_W'($urandom_range(65, 1024));
            else             it.dma_length = LEN_W'($urandom_range(1, 64));
        end else if (pick < 60) begin
            it.action = ACT_WORD;
        end else if (pick < 96) begin
            it.action = ACT_PLAY;
        end else begin
            it.action = ACT_UNUSED;
        end
        return it;
    endfunction

    // enter and leave at a falling edge
    task automatic send_item(input t_in it);
        if (tx_idle && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (pending != 0) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_limit(input logic [CFG_W-1:0] value);
        wait_drained();
        repeat (4) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [CFG_W-1:0] limits [PHASES];
        logic [CFG_W-1:0] lim;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        tx_idle   = 1'b1;
        rx_idle   = 1'b1;
        hold_req  = 1'b0;
        limits    = '{12'd0, 12'd4095, 12'd1, 12'd2, 12'd16, 12'd2048,
                      12'd3, 12'd0, 12'd7, 12'd1, 12'd5, 12'd2048};

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed run at the reset limit
        send_item(make_item(ACT_PLAY,  '0,          32'h1234_5678, 1'b1));
        send_item(make_item(ACT_WORD,  '0,          32'hDEAD_BEEF, 1'b0));
        send_item(make_item(ACT_QUEUE, '0,          32'h0,         1'b0));
        send_item(make_item(ACT_QUEUE, LEN_W'(6),   32'h0,         1'b0));
        send_item(make_item(ACT_QUEUE, '1,          32'hFFFF_FFFF, 1'b1));
        send_item(make_item(ACT_QUEUE, LEN_W'(3),   32'h0,         1'b0));
        send_item(make_item(ACT_WORD,  '1,          32'h7FFF_8000, 1'b0));
        send_item(make_item(ACT_WORD,  '0,          32'hFFFF_FFFF, 1'b1));
        send_item(make_item(ACT_WORD,  '0,          32'h8000_7FFF, 1'b0));
        send_item(make_item(ACT_WORD,  '0,          32'h0000_0000, 1'b0));
        send_item(make_item(ACT_PLAY,  '1,          32'hFFFF_FFFF, 1'b0));
        send_item(make_item(ACT_PLAY,  '0,          32'h0,         1'b1));
        send_item(make_item(ACT_PLAY,  '0,          32'h0,         1'b1));
        send_item(make_item(ACT_PLAY,  '0,          32'h0,         1'b1));
        send_item(make_item(ACT_PLAY,  '0,          32'h0,         1'b1));
        send_item(make_item(ACT_PLAY,  '0,          32'h0,         1'b1));
        send_item(make_item(ACT_PLAY,  '0,          32'h0,         1'b0));
        send_item(make_item(ACT_UNUSED, '1,         32'hFFFF_FFFF, 1'b1));
        send_item(make_item(ACT_QUEUE, LEN_W'(8),   32'h0,         1'b0));
        send_item(make_item(ACT_PLAY,  '0,          32'h0,         1'b1));
        send_item(make_item(ACT_WORD,  '0,          $urandom,      1'b0));
        send_item(make_item(ACT_WORD,  '0,          $urandom,      1'b1));
        in_valid <= 1'b0;

        for (int p = 0; p < PHASES; p++) begin
            lim = (p == 7) ? CFG_W'($urandom_range(0, 4095)) : limits[p];
            write_limit(lim);
            tx_idle = (p != PHASES - 1);
            rx_idle = (p != PHASES - 1);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 4 && i == 40) hold_req = 1'b1;
                if (p == 6 && i == 70) begin
                    in_valid <= 1'b0;
                    wait_drained();
                end
                send_item(random_item());
            end
            in_valid <= 1'b0;
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("audio_dma_double_buffer_fifo verification clean");
        end else begin
            $display("audio_dma_double_buffer_fifo verification failed");
        end
        $finish;
    end

endmodule

@@ audio_dma_double_buffer_fifo.f @@
src/adb_pkg.sv
src/adb_ram.sv
src/adb_ctrl.sv
src/adb_play.sv
src/audio_dma_double_buffer_fifo.sv
sim/adb_checker.sv
sim/tb.sv
